### src/efa_pkg.sv
`default_nettype none
package efa_pkg;

  localparam int MAX_X      = 256;
  localparam int MAX_Y      = 256;
  localparam int COUNT_BITS = 16;

  localparam int CELLS     = MAX_X * MAX_Y;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int WORD_W    = 16;
  localparam int COORD_W   = 15;
  localparam int EXT_W     = 9;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int PROD_W    = COORD_W + EXT_W;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [WORD_W-1:0] COORD_MASK = 16'h7FFF;
  localparam logic [EXT_W-1:0]  EXT_RESET  = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_EVENT = 2'd0,
    CMD_SWAP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_EXTENT = 1'b0,
    CFG_Y_EXTENT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic commit;
    logic clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

### src/event_frame_accumulator_top.sv
// Event frame accumulator with two ping-pong count banks.
// The input channel (in_valid/in_ready) carries a command with two raw
// coordinate words: an event increments one cell of the active bank, a swap
// exchanges the banks, and a read returns one cell of the frozen bank and
// clears it. Every input transfer yields exactly one result transfer on the
// output channel (out_valid/out_ready) with a count and an out-of-range flag.
// The configuration channel (cfg_valid/cfg_ready) sets the x and y extents
// and is always ready; it should be written only while the block is idle.
// After its input transfer an item passes through a read step of the bank RAM
// and a write-back step that also registers its result; in_ready stays low
// until that write-back is done, so no new item is taken before then.
// After reset both banks are cleared one cell per cycle in parallel, over all
// 65536 cells; in_ready stays low during that sweep.
// The result sits in an output register, so a new item is accepted while a
// result waits; if the receiver stalls, the following item waits in its
// write-back step until the output register is free.
`default_nettype none
module event_frame_accumulator_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [efa_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [efa_pkg::WORD_W-1:0]         in_y_word,
  input  wire logic [efa_pkg::WORD_W-1:0]         in_x_word,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [efa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [efa_pkg::EXT_W-1:0]          cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [efa_pkg::COUNT_BITS-1:0]     out_count,
  output logic                                    out_status
);
  import efa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  efa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  efa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_cmd     (in_cmd),
    .in_y_word  (in_y_word),
    .in_x_word  (in_x_word),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_count  (out_count),
    .out_status (out_status)
  );

endmodule
`default_nettype wire

### src/efa_ram.sv
`default_nettype none
module efa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### src/efa_ctrl.sv
`default_nettype none
module efa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire efa_pkg::dp_status_t status,
  output efa_pkg::ctrl_cmd_t       cmd
);
  import efa_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_LOOK: begin
        cmd.lookup = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/efa_dp.sv
`default_nettype none
module efa_dp (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire efa_pkg::ctrl_cmd_t                      cmd,
  output efa_pkg::dp_status_t                          status,
  input  wire logic [efa_pkg::CMD_W-1:0]               in_cmd,
  input  wire logic [efa_pkg::WORD_W-1:0]              in_y_word,
  input  wire logic [efa_pkg::WORD_W-1:0]              in_x_word,
  input  wire logic                                    cfg_valid,
  input  wire logic [efa_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  wire logic [efa_pkg::EXT_W-1:0]               cfg_data,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic      [efa_pkg::COUNT_BITS-1:0]          out_count,
  output logic                                         out_status
);
  import efa_pkg::*;

  logic [EXT_W-1:0]      x_extent_r;
  logic [EXT_W-1:0]      y_extent_r;
  cmd_t                  cmd_r;
  logic [COORD_W-1:0]    x_r;
  logic [COORD_W-1:0]    y_r;
  logic                  active_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic                  out_valid_r;
  logic [COUNT_BITS-1:0] out_count_r;
  logic                  out_status_r;

  logic [EXT_W-1:0]      xe;
  logic [EXT_W-1:0]      ye;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      idx_sum;
  logic                  in_range;
  logic [ADDR_W-1:0]     addr;
  logic                  is_event;
  logic                  is_read;
  logic                  tgt_bank;
  logic [COUNT_BITS-1:0] rdata0;
  logic [COUNT_BITS-1:0] rdata1;
  logic [COUNT_BITS-1:0] rdata;
  logic [COUNT_BITS-1:0] new_val;
  logic                  do_write;
  logic                  we0;
  logic                  we1;
  logic [ADDR_W-1:0]     waddr;
  logic [COUNT_BITS-1:0] wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_extent_r <= EXT_RESET;
      y_extent_r <= EXT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_X_EXTENT: x_extent_r <= cfg_data;
        CFG_Y_EXTENT: y_extent_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= cmd_t'(in_cmd);
      y_r   <= COORD_W'(in_y_word & COORD_MASK);
      x_r   <= COORD_W'(in_x_word & COORD_MASK);
    end
  end

  assign xe = (x_extent_r > EXT_W'(MAX_X)) ? EXT_W'(MAX_X) : x_extent_r;
  assign ye = (y_extent_r > EXT_W'(MAX_Y)) ? EXT_W'(MAX_Y) : y_extent_r;

  assign prod     = PROD_W'(x_r) * PROD_W'(ye);
  assign idx_sum  = SUM_W'(prod) + SUM_W'(y_r);
  assign in_range = (COORD_W'(xe) > x_r) && (COORD_W'(ye) > y_r)
                    && (idx_sum < SUM_W'(CELLS));
  assign addr     = idx_sum[ADDR_W-1:0];

  assign is_event = (cmd_r == CMD_EVENT);
  assign is_read  = (cmd_r == CMD_READ);
  assign tgt_bank = is_read ? ~active_r : active_r;
  assign rdata    = tgt_bank ? rdata1 : rdata0;
  assign new_val  = is_read ? '0 : ((rdata == '1) ? rdata : rdata + 1'b1);
  assign do_write = cmd.commit && in_range && (is_event || is_read);

  assign waddr = cmd.clr ? clr_addr_r : addr;
  assign wdata = cmd.clr ? '0 : new_val;
  assign we0   = cmd.clr || (do_write && !tgt_bank);
  assign we1   = cmd.clr || (do_write && tgt_bank);

  efa_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.lookup),
    .raddr (addr),
    .rdata (rdata0)
  );

  efa_ram #(.WIDTH(COUNT_BITS), .DEPTH(CELLS)) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.lookup),
    .raddr (addr),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.commit && (cmd_r == CMD_SWAP)) begin
        active_r <= ~active_r;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_count_r  <= (is_read && in_range) ? rdata : '0;
      out_status_r <= (is_event || is_read) && !in_range;
    end
  end

  assign status.clear_last = (clr_addr_r == ADDR_W'(CELLS - 1));
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire
